[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

[hdl/dsr_pkg.sv]
// Package of the descending sequence release block: sizes and sequencer states.
// Depends on nothing; used by the interfaces, the store RAM user and the top level.
package dsr_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int VALUE_W     = 20;
   localparam int EXP_W       = VALUE_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SHIFT = 6'b000010,
      ST_PLACE = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_SPARE = 6'b100000
   } state_type;

endpackage

[hdl/dsr_if.sv]
// Request and response channel interfaces of the descending sequence release block.
// Depends on dsr_pkg for the field widths.
interface dsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [dsr_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface dsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dsr_pkg::VALUE_W-1:0] released_value;
   logic                        has_value;
   logic                        last;
   logic                        dropped_full;

   modport source (output valid, output released_value, output has_value,
                   output last, output dropped_full, input ready);
   modport sink (input valid, input released_value, input has_value,
                 input last, input dropped_full, output ready);
endinterface

[hdl/dsr_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module dsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/descending_sequence_release_top.sv]
// Descending sequence release: keeps up to STORE_DEPTH values sorted in one store RAM and
// releases the largest one while it equals the expected value, which a csr write loads and
// each release counts down. A request is accepted in ST_IDLE; the sorted insert moves up
// each stored entry not below the value in ST_SHIFT (at most STORE_DEPTH - 1) and writes
// the value there, or in ST_PLACE once all have moved; each release passes ST_FETCH and
// ST_CHECK; the request ends from ST_FETCH when the store has run empty, else from ST_CHECK;
// a waiting response holds the sequencer. The single store RAM port pair sets these steps.
// Depends on dsr_pkg, dsr_if and dsr_ram.
module descending_sequence_release_top (
   input  logic                        clock,
   input  logic                        reset,
   dsr_req_if.sink                     req_bus,
   dsr_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [dsr_pkg::VALUE_W-1:0] csr_wdata
);

   dsr_pkg::state_type                state_ff, state_in;
   logic [dsr_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [dsr_pkg::EXP_W-1:0]  exp_ff, exp_in;
   logic [dsr_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic [dsr_pkg::VALUE_W-1:0]       val_ff, val_in;
   logic                              drop_ff, drop_in;
   logic                              pend_ff, pend_in;
   logic [dsr_pkg::VALUE_W-1:0]       pend_val_ff, pend_val_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dsr_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                              rsp_has_ff, rsp_has_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_drop_ff, rsp_drop_in;

   logic                              wr_en;
   logic [dsr_pkg::ADDR_W-1:0]        wr_addr;
   logic [dsr_pkg::VALUE_W-1:0]       wr_data;
   logic [dsr_pkg::ADDR_W-1:0]        rd_addr;
   logic [dsr_pkg::VALUE_W-1:0]       rd_data;

   logic [dsr_pkg::CNT_W-1:0]         count_dec;
   logic [dsr_pkg::ADDR_W-1:0]        top_addr;
   logic                              out_free;
   logic                              load;
   logic                              eligible;
   logic                              top_match;

   dsr_ram #(
      .WIDTH (dsr_pkg::VALUE_W),
      .DEPTH (dsr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_dec = count_ff - dsr_pkg::CNT_W'(1);
   assign top_addr  = count_dec[dsr_pkg::ADDR_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign eligible  = $signed({1'b0, req_bus.value}) <= exp_ff;
   assign top_match = $signed({1'b0, rd_data}) == exp_ff;

   assign req_bus.ready = (state_ff == dsr_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      drop_in      = drop_ff;
      pend_in      = pend_ff;
      pend_val_in  = pend_val_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      rd_addr      = top_addr;
      load         = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;

      case (state_ff)
         dsr_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               val_in  = req_bus.value;
               drop_in = 1'b0;
               pend_in = 1'b0;
               state_in = dsr_pkg::ST_FETCH;
               if (eligible) begin
                  if (count_ff == dsr_pkg::CNT_W'(dsr_pkg::STORE_DEPTH)) begin
                     drop_in = 1'b1;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_bus.value;
                     count_in = dsr_pkg::CNT_W'(1);
                  end else begin
                     rd_addr  = top_addr;
                     idx_in   = top_addr;
                     state_in = dsr_pkg::ST_SHIFT;
                  end
               end
            end
         end
         dsr_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + dsr_pkg::ADDR_W'(1);
            if (rd_data >= val_ff) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = dsr_pkg::ST_PLACE;
               end else begin
                  idx_in  = idx_ff - dsr_pkg::ADDR_W'(1);
                  rd_addr = idx_ff - dsr_pkg::ADDR_W'(1);
               end
            end else begin
               wr_data  = val_ff;
               count_in = count_ff + dsr_pkg::CNT_W'(1);
               state_in = dsr_pkg::ST_FETCH;
            end
         end
         dsr_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = val_ff;
            count_in = count_ff + dsr_pkg::CNT_W'(1);
            state_in = dsr_pkg::ST_FETCH;
         end
         dsr_pkg::ST_FETCH: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  load         = 1'b1;
                  rsp_value_in = pend_ff ? pend_val_ff : '0;
                  rsp_has_in   = pend_ff;
                  rsp_last_in  = 1'b1;
                  rsp_drop_in  = drop_ff;
                  state_in     = dsr_pkg::ST_IDLE;
               end
            end else begin
               state_in = dsr_pkg::ST_CHECK;
            end
         end
         dsr_pkg::ST_CHECK: begin
            if (out_free) begin
               if (top_match) begin
                  load         = pend_ff;
                  rsp_value_in = pend_val_ff;
                  rsp_has_in   = 1'b1;
                  rsp_last_in  = 1'b0;
                  rsp_drop_in  = drop_ff;
                  pend_in      = 1'b1;
                  pend_val_in  = rd_data;
                  count_in     = count_dec;
                  exp_in       = exp_ff - dsr_pkg::EXP_W'(1);
                  state_in     = dsr_pkg::ST_FETCH;
               end else begin
                  load         = 1'b1;
                  rsp_value_in = pend_ff ? pend_val_ff : '0;
                  rsp_has_in   = pend_ff;
                  rsp_last_in  = 1'b1;
                  rsp_drop_in  = drop_ff;
                  state_in     = dsr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dsr_pkg::ST_IDLE;
         end
      endcase

      if (csr_we) begin
         exp_in = $signed({1'b0, csr_wdata});
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsr_pkg::ST_IDLE;
         count_ff     <= '0;
         exp_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         exp_ff       <= exp_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      drop_ff     <= drop_in;
      pend_val_ff <= pend_val_in;
      if (load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_has_ff   <= rsp_has_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_drop_ff  <= rsp_drop_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.released_value = rsp_value_ff;
   assign rsp_bus.has_value      = rsp_has_ff;
   assign rsp_bus.last           = rsp_last_ff;
   assign rsp_bus.dropped_full   = rsp_drop_ff;

endmodule

[hdl/dsr_checker.sv]
// Port-level checker of the descending sequence release block, bound to the top level.
// Depends on assert_macros.svh and dsr_pkg.
`include "assert_macros.svh"

module dsr_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dsr_pkg::VALUE_W-1:0] rsp_released_value,
   input logic                        rsp_has_value,
   input logic                        rsp_last
);

   // A pending response is held until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // An accepted request keeps the block busy for at least the next cycle.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // An empty response carries a zero value and closes its request.
   `ASSERT_SAME(a_empty_rsp, clock, reset, rsp_valid && !rsp_has_value,
                rsp_last && (rsp_released_value == '0))

endmodule

bind descending_sequence_release_top dsr_port_checker u_dsr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_released_value (rsp_bus.released_value),
   .rsp_has_value      (rsp_bus.has_value),
   .rsp_last           (rsp_bus.last)
);
